[hw/rtl/sha256_pkg.sv]
`timescale 1ns / 1ps

package sha256_pkg;

  localparam int unsigned BlockBits = 512;
  localparam int unsigned WordBits  = 32;
  localparam int unsigned HashWords = 8;
  localparam int unsigned Rounds    = 64;

  localparam logic ActAbsorb = 1'b0;
  localparam logic ActFinish = 1'b1;

  localparam logic [7:0] PadOneByte  = 8'h80;
  localparam logic [7:0] PadZeroByte = 8'h00;

  // byte position where the bit length field starts
  localparam logic [5:0] LenFill = 6'd56;

  localparam logic [WordBits-1:0] InitHash [HashWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WordBits-1:0] RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [1:0] {
    BS_DATA = 2'd0,
    BS_ONE  = 2'd1,
    BS_ZERO = 2'd2,
    BS_LEN  = 2'd3
  } byte_sel_e;

  // controller to datapath
  typedef struct packed {
    logic      shift_en;
    byte_sel_e byte_sel;
    logic      count_en;
    logic      finish_start;
    logic      start_block;
    logic      round_en;
    logic      fold_en;
    logic      emit_en;
    logic      reinit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fill_last;
    logic fill_at56;
    logic round_last;
    logic emit_last;
    logic out_free;
  } sts_t;

  function automatic logic [WordBits-1:0] rotr(input logic [WordBits-1:0] x,
                                               input int unsigned n);
    rotr = (x >> n) | (x << (WordBits - n));
  endfunction

  function automatic logic [WordBits-1:0] big_sig0(input logic [WordBits-1:0] x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [WordBits-1:0] big_sig1(input logic [WordBits-1:0] x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [WordBits-1:0] small_sig0(input logic [WordBits-1:0] x);
    small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WordBits-1:0] small_sig1(input logic [WordBits-1:0] x);
    small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

[hw/rtl/sha256_if.sv]
`timescale 1ns / 1ps

interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;

  modport source (output valid, action, data_byte, input ready);
  modport sink (input valid, action, data_byte, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

[hw/rtl/sha256_dp.sv]
`timescale 1ns / 1ps

module sha256_dp import sha256_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [7:0]  data_byte_i,
  output sts_t        sts_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  // block window: bytes shift in at the low end, schedule words during rounds
  logic [BlockBits-1:0] blk_q, blk_d;
  logic [5:0]           fill_q;
  logic [63:0]          byte_cnt_q;
  logic [63:0]          len_q;
  logic [5:0]           rnd_q;
  logic [WordBits-1:0]  work_q [HashWords];
  logic [WordBits-1:0]  hash_q [HashWords];
  logic [2:0]           emit_idx_q;
  logic                 out_valid_q;
  logic [WordBits-1:0]  out_word_q;
  logic [2:0]           out_idx_q;
  logic                 out_last_q;

  logic [7:0]          pad_byte;
  logic [WordBits-1:0] w_cur, sched_new, t1, t2, ch, maj;

  always_comb begin
    unique case (cmd_i.byte_sel)
      BS_DATA: pad_byte = data_byte_i;
      BS_ONE:  pad_byte = PadOneByte;
      BS_ZERO: pad_byte = PadZeroByte;
      BS_LEN:  pad_byte = len_q[63:56];
      default: pad_byte = data_byte_i;
    endcase
  end

  assign w_cur     = blk_q[511:480];
  assign sched_new = w_cur + small_sig0(blk_q[479:448]) + blk_q[223:192]
                   + small_sig1(blk_q[63:32]);

  assign ch  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
  assign maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
  assign t1  = work_q[7] + big_sig1(work_q[4]) + ch + RoundK[rnd_q] + w_cur;
  assign t2  = big_sig0(work_q[0]) + maj;

  always_comb begin
    blk_d = blk_q;
    if (cmd_i.shift_en) begin
      blk_d = {blk_q[BlockBits-9:0], pad_byte};
    end else if (cmd_i.round_en) begin
      blk_d = {blk_q[BlockBits-WordBits-1:0], sched_new};
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    if (cmd_i.finish_start) begin
      len_q <= {byte_cnt_q[60:0], 3'b000};
    end else if (cmd_i.shift_en && cmd_i.byte_sel == BS_LEN) begin
      len_q <= {len_q[55:0], 8'h00};
    end
    if (cmd_i.start_block) begin
      for (int i = 0; i < HashWords; i++) work_q[i] <= hash_q[i];
    end else if (cmd_i.round_en) begin
      work_q[7] <= work_q[6];
      work_q[6] <= work_q[5];
      work_q[5] <= work_q[4];
      work_q[4] <= work_q[3] + t1;
      work_q[3] <= work_q[2];
      work_q[2] <= work_q[1];
      work_q[1] <= work_q[0];
      work_q[0] <= t1 + t2;
    end
    if (cmd_i.emit_en) begin
      out_word_q <= hash_q[0];
      out_idx_q  <= emit_idx_q;
      out_last_q <= &emit_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      byte_cnt_q  <= '0;
      rnd_q       <= '0;
      emit_idx_q  <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < HashWords; i++) hash_q[i] <= InitHash[i];
    end else begin
      if (cmd_i.shift_en) begin
        fill_q <= fill_q + 6'd1;
      end
      if (cmd_i.finish_start) begin
        byte_cnt_q <= '0;
      end else if (cmd_i.count_en) begin
        byte_cnt_q <= byte_cnt_q + 64'd1;
      end
      if (cmd_i.start_block) begin
        rnd_q <= '0;
      end else if (cmd_i.round_en) begin
        rnd_q <= rnd_q + 6'd1;
      end
      if (cmd_i.reinit) begin
        for (int i = 0; i < HashWords; i++) hash_q[i] <= InitHash[i];
      end else if (cmd_i.emit_en) begin
        for (int i = 0; i < HashWords - 1; i++) hash_q[i] <= hash_q[i+1];
      end else if (cmd_i.fold_en) begin
        for (int i = 0; i < HashWords; i++) hash_q[i] <= hash_q[i] + work_q[i];
      end
      if (cmd_i.emit_en) begin
        emit_idx_q <= emit_idx_q + 3'd1;
      end
      if (cmd_i.emit_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.fill_last  = &fill_q;
  assign sts_o.fill_at56  = (fill_q == LenFill);
  assign sts_o.round_last = &rnd_q;
  assign sts_o.emit_last  = &emit_idx_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign digest_word_o = out_word_q;
  assign word_index_o  = out_idx_q;
  assign last_word_o   = out_last_q;

endmodule

[hw/rtl/sha256_ctrl.sv]
`timescale 1ns / 1ps

module sha256_ctrl import sha256_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_action_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b000_0001,
    S_PAD_ONE  = 7'b000_0010,
    S_PAD_ZERO = 7'b000_0100,
    S_PAD_LEN  = 7'b000_1000,
    S_ROUND    = 7'b001_0000,
    S_FOLD     = 7'b010_0000,
    S_EMIT     = 7'b100_0000
  } state_e;

  state_e state_q, state_d;
  logic   fin_q, fin_d;
  logic   len_sent_q, len_sent_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    fin_d      = fin_q;
    len_sent_d = len_sent_q;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_action_i == ActAbsorb) begin
            cmd_o.shift_en = 1'b1;
            cmd_o.count_en = 1'b1;
            if (sts_i.fill_last) begin
              cmd_o.start_block = 1'b1;
              state_d           = S_ROUND;
            end
          end else begin
            cmd_o.finish_start = 1'b1;
            fin_d              = 1'b1;
            state_d            = S_PAD_ONE;
          end
        end
      end
      S_PAD_ONE: begin
        cmd_o.shift_en = 1'b1;
        cmd_o.byte_sel = BS_ONE;
        if (sts_i.fill_last) begin
          cmd_o.start_block = 1'b1;
          state_d           = S_ROUND;
        end else begin
          state_d = S_PAD_ZERO;
        end
      end
      S_PAD_ZERO: begin
        // zeros run up to the length field at byte 56, or to the end of the block when it is already past byte 56
        if (sts_i.fill_last) begin
          cmd_o.shift_en    = 1'b1;
          cmd_o.byte_sel    = BS_ZERO;
          cmd_o.start_block = 1'b1;
          state_d           = S_ROUND;
        end else if (!sts_i.fill_at56) begin
          cmd_o.shift_en = 1'b1;
          cmd_o.byte_sel = BS_ZERO;
        end else begin
          state_d = S_PAD_LEN;
        end
      end
      S_PAD_LEN: begin
        cmd_o.shift_en = 1'b1;
        cmd_o.byte_sel = BS_LEN;
        if (sts_i.fill_last) begin
          cmd_o.start_block = 1'b1;
          len_sent_d        = 1'b1;
          state_d           = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd_o.round_en = 1'b1;
        if (sts_i.round_last) begin
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd_o.fold_en = 1'b1;
        if (!fin_q) begin
          state_d = S_IDLE;
        end else if (len_sent_q) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_PAD_ZERO;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_en = 1'b1;
          if (sts_i.emit_last) begin
            cmd_o.reinit = 1'b1;
            fin_d        = 1'b0;
            len_sent_d   = 1'b0;
            state_d      = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fin_q      <= 1'b0;
      len_sent_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      fin_q      <= fin_d;
      len_sent_q <= len_sent_d;
    end
  end

`ifndef SYNTH
  a_block_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start_block |-> (cmd_o.shift_en && sts_i.fill_last))
    else $error("block started before buffer full");

  a_rounds_then_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND && sts_i.round_last) |=> state_q == S_FOLD)
    else $error("fold did not follow last round");

  a_emit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_en |-> sts_i.out_free)
    else $error("digest word overwrote a pending result");

  a_emit_after_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (fin_q && len_sent_q))
    else $error("digest emitted before length block");
`endif

endmodule

[hw/rtl/sha256_byte_stream_hasher.sv]
`timescale 1ns / 1ps

// SHA-256 over a byte stream. An absorb transfer (action 0) takes one byte per
// cycle into the 512-bit block window while input ready is high; the 64th byte
// of a block starts the single round unit, which runs the rounds and then folds
// the working words into the chaining words, and input ready is low meanwhile.
// A finish transfer (action 1) inserts the 0x80 byte, zero padding and the
// 8-byte bit length, runs the rounds and the fold for each of the one or two
// padded blocks, then sends the digest as eight 32-bit words, most significant
// first, one per cycle while the sink takes them; last_word marks the eighth.
// The hasher is then reset to the initial hash for the next message and accepts
// input while the final digest word still waits in the output register.
module sha256_byte_stream_hasher import sha256_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sha256_in_if.sink    in_i,
  sha256_out_if.source out_o
);

  cmd_t cmd;
  sts_t sts;

  sha256_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sha256_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (in_i.data_byte),
    .sts_o         (sts),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .digest_word_o (out_o.digest_word),
    .word_index_o  (out_o.word_index),
    .last_word_o   (out_o.last_word)
  );

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import sha256_pkg::*;

  localparam logic [255:0] EmptyDigest =
    256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
  localparam logic [255:0] AbcDigest =
    256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

  localparam logic [31:0] IvWords [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } word_beat_t;

  typedef struct packed {
    logic         act;
    logic [7:0]   data;
    logic         known;
    logic [255:0] digest;
  } stim_row_t;

  localparam int NumRows = 14;
  localparam int RandItems = 336;

  // rows with a known digest are checked against the typed value
  localparam stim_row_t DirRows [NumRows] = '{
    '{ActFinish, 8'hff, 1'b1, EmptyDigest},  // empty message right after reset
    '{ActAbsorb, 8'h61, 1'b0, 256'h0},
    '{ActAbsorb, 8'h62, 1'b0, 256'h0},
    '{ActAbsorb, 8'h63, 1'b0, 256'h0},
    '{ActFinish, 8'h00, 1'b1, AbcDigest},
    '{ActAbsorb, 8'h00, 1'b0, 256'h0},
    '{ActAbsorb, 8'hff, 1'b0, 256'h0},
    '{ActAbsorb, 8'h80, 1'b0, 256'h0},
    '{ActFinish, 8'ha5, 1'b0, 256'h0},
    '{ActFinish, 8'h00, 1'b1, EmptyDigest},  // back to back finish, state reinit
    '{ActAbsorb, 8'h55, 1'b0, 256'h0},
    '{ActAbsorb, 8'haa, 1'b0, 256'h0},
    '{ActFinish, 8'h5a, 1'b0, 256'h0},
    '{ActFinish, 8'hff, 1'b1, EmptyDigest}
  };

  localparam int Boundaries [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  logic clk_i;
  logic rst_ni;
  logic calm;

  sha256_in_if  in_if ();
  sha256_out_if out_if ();

  sha256_byte_stream_hasher dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // running hash state of the predictor
  logic [31:0] chain_words [8];
  logic [7:0]  blk_bytes [64];
  logic [63:0] msg_len;

  word_beat_t digest_due [$];
  int n_bad;
  int n_bytes;
  int n_msgs;
  int n_words;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_chain();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2, ch, mj;
    for (int t = 0; t < 16; t++) begin
      w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
    end
    for (int t = 16; t < 64; t++) begin
      s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = chain_words[i];
    for (int t = 0; t < 64; t++) begin
      s1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1 = v[7] + s1 + ch + RoundConst[t] + w[t];
      s0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
      mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t2 = s0 + mj;
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_words[i] = chain_words[i] + v[i];
  endfunction

  function automatic void reinit_hash();
    for (int i = 0; i < 8; i++) chain_words[i] = IvWords[i];
    msg_len = '0;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    blk_bytes[msg_len[5:0]] = b;
    msg_len = msg_len + 64'd1;
    if (msg_len[5:0] == 6'd0) compress_chain();
  endfunction

  function automatic void put_pad(inout int fill, input logic [7:0] b);
    blk_bytes[fill[5:0]] = b;
    fill++;
    if (fill == 64) begin
      compress_chain();
      fill = 0;
    end
  endfunction

  function automatic void finish_message(output logic [255:0] dig);
    logic [63:0] bit_len;
    int fill;
    fill = int'(msg_len[5:0]);
    bit_len = msg_len << 3;
    put_pad(fill, 8'h80);
    while (fill != 56) put_pad(fill, 8'h00);
    for (int i = 0; i < 8; i++) put_pad(fill, bit_len[63-8*i -: 8]);
    for (int i = 0; i < 8; i++) dig[255-32*i -: 32] = chain_words[i];
    reinit_hash();
  endfunction

  function automatic void queue_digest(input logic [255:0] dig);
    word_beat_t beat;
    for (int i = 0; i < 8; i++) begin
      beat.word = dig[255-32*i -: 32];
      beat.idx  = 3'(i);
      beat.last = (i == 7);
      digest_due.push_back(beat);
    end
  endfunction

  // drive one transfer and update the predictor once it is taken
  task automatic apply_item(input logic act, input logic [7:0] b, input logic known,
                            input logic [255:0] typed);
    logic [255:0] dig;
    while (!calm && $urandom_range(0, 99) < 19) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.action    <= act;
    in_if.data_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (act == ActAbsorb) begin
      absorb_byte(b);
      n_bytes++;
    end else begin
      finish_message(dig);
      queue_digest(known ? typed : dig);
      n_msgs++;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_if.ready <= rst_ni && (calm || $urandom_range(0, 99) >= 19);
  end

  always @(posedge clk_i) begin
    word_beat_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_words++;
      if (digest_due.size() == 0) begin
        $display("%0t: unexpected digest transfer word %h index %0d last %b", $time,
                 out_if.digest_word, out_if.word_index, out_if.last_word);
        n_bad++;
      end else begin
        want = digest_due.pop_front();
        if (out_if.digest_word !== want.word) begin
          $display("%0t: digest_word expected %h actual %h", $time, want.word,
                   out_if.digest_word);
          n_bad++;
        end
        if (out_if.word_index !== want.idx) begin
          $display("%0t: word_index expected %0d actual %0d", $time, want.idx,
                   out_if.word_index);
          n_bad++;
        end
        if (out_if.last_word !== want.last) begin
          $display("%0t: last_word expected %b actual %b", $time, want.last,
                   out_if.last_word);
          n_bad++;
        end
      end
    end
  end

  initial begin
    int n_rand;
    int rand_msgs;
    int len;
    int pick;
    n_bad   = 0;
    n_bytes = 0;
    n_msgs  = 0;
    n_words = 0;
    n_rand  = 0;
    rand_msgs = 0;
    calm    = 1'b0;
    for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
    reinit_hash();
    in_if.valid     = 1'b0;
    in_if.action    = ActAbsorb;
    in_if.data_byte = 8'h00;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumRows; r++) begin
      apply_item(DirRows[r].act, DirRows[r].data, DirRows[r].known, DirRows[r].digest);
    end

    // random messages, lengths biased toward the one/two padding block edges
    while (n_rand < RandItems || rand_msgs < 6) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) len = $urandom_range(0, 12);
      else if (pick < 7) len = Boundaries[$urandom_range(0, 9)];
      else len = $urandom_range(0, 130);
      // keep room for the finish within the item budget
      if (n_rand + len >= RandItems) len = (n_rand < RandItems - 1) ? RandItems - 1 - n_rand : 0;
      for (int k = 0; k < len; k++) begin
        calm = (n_rand >= 120 && n_rand < 200);
        apply_item(ActAbsorb, 8'($urandom_range(0, 255)), 1'b0, 256'h0);
        n_rand++;
      end
      // data byte on a finish is ignored, keep it random
      apply_item(ActFinish, 8'($urandom_range(0, 255)), 1'b0, 256'h0);
      n_rand++;
      rand_msgs++;
    end
    calm = 1'b0;
    in_if.valid <= 1'b0;

    while (digest_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (digest_due.size() != 0) begin
      $display("%0t: %0d digest words never arrived", $time, digest_due.size());
      n_bad++;
    end

    $display("hashed %0d messages from %0d data bytes, %0d digest words checked",
             n_msgs, n_bytes, n_words);
    $display("covered empty and known messages plus one and two block padding lengths");
    if (n_bad == 0) begin
      $display("** sha256_byte_stream_hasher: PASSED **");
    end else begin
      $display("** sha256_byte_stream_hasher: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting for transfers");
    $display("** sha256_byte_stream_hasher: FAILED **");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_if.sv
hw/rtl/sha256_dp.sv
hw/rtl/sha256_ctrl.sv
hw/rtl/sha256_byte_stream_hasher.sv
dv/tb_top.sv
